// ===== design/ordered_list_insert_erase_assert.svh =====
// Assertion macros shared by the ordered list modules.
`ifndef ORDERED_LIST_INSERT_ERASE_ASSERT_SVH
`define ORDERED_LIST_INSERT_ERASE_ASSERT_SVH

`ifndef SYNTHESIS

`define OLIE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ordered list assertion failed");

`define OLIE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list assertion failed");

`else

`define OLIE_ASSERT_NOW(name, clk, rst, ante, cons)

`define OLIE_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/olie_pkg.sv =====
// Types, constants and command/status structs of the ordered list.
`default_nettype none

package olie_pkg;

   localparam int CAPACITY    = 64;
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);
   localparam int OPCODE_W    = 3;
   localparam int POS_W       = 7;
   localparam int DATA_W      = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;
   localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_ERASE  = 3'd3,
      OP_READ   = 3'd4,
      OP_WRITE  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_READ,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      WR_COUNT_VAL,
      WR_POS_VAL,
      WR_CUR_SHIFT
   } wr_sel_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_CUR_DN,
      RD_CUR_UP
   } rd_sel_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_INC,
      CNT_DEC
   } cnt_op_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_LOAD_COUNT,
      CUR_LOAD_POS,
      CUR_INC,
      CUR_DEC
   } cur_op_type;

   typedef struct packed {
      logic       load_req;
      cur_op_type cur_op;
      logic       mem_wr;
      wr_sel_type wr_sel;
      logic       mem_rd;
      rd_sel_type rd_sel;
      cnt_op_type cnt_op;
      logic       rsp_load;
      status_type rsp_status;
      logic       rsp_use_rd;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   full;
      logic   empty;
      logic   pos_gt_cnt;
      logic   pos_ge_cnt;
      logic   cur_at_pos;
      logic   cur_at_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/olie_req_if.sv =====
// Request channel interface: opcode, position and value beats.
`default_nettype none

interface olie_req_if;
   import olie_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OPCODE_W-1:0]        opcode;
   logic [POS_W-1:0]           position;
   logic signed [DATA_W-1:0]   value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

// ===== design/olie_rsp_if.sv =====
// Response channel interface: read data, entry count and status beats.
`default_nettype none

interface olie_rsp_if;
   import olie_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   read_data;
   logic [COUNT_OUT_W-1:0]     entry_count;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, output read_data, output entry_count, output status,
                   input ready);
   modport sink   (input valid, input read_data, input entry_count, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== design/olie_dp.sv =====
// Datapath of the ordered list: entry memory, count, cursor and response registers.
`default_nettype none

`include "ordered_list_insert_erase_assert.svh"

module olie_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  olie_pkg::cmd_type                 cmd,
   output olie_pkg::stat_type                stat,
   input  logic [olie_pkg::OPCODE_W-1:0]     req_opcode,
   input  logic [olie_pkg::POS_W-1:0]        req_position,
   input  logic signed [olie_pkg::DATA_W-1:0] req_value,
   output logic signed [olie_pkg::DATA_W-1:0] rsp_read_data,
   output logic [olie_pkg::COUNT_OUT_W-1:0]  rsp_entry_count,
   output logic [olie_pkg::STATUS_W-1:0]     rsp_status
);
   import olie_pkg::*;

   logic [DATA_W-1:0]      entry_mem [CAPACITY];
   logic [DATA_W-1:0]      mem_q_ff;

   op_type                 op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [DATA_W-1:0]      val_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       cursor_ff, cursor_in;
   logic [DATA_W-1:0]      rsp_data_ff;
   logic [COUNT_OUT_W-1:0] rsp_count_ff;
   status_type             rsp_status_ff;

   logic [ADDR_W-1:0]      wr_addr;
   logic [DATA_W-1:0]      wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [CMP_W-1:0]       pos_cmp;
   logic [CMP_W-1:0]       cnt_cmp;

   always_comb begin
      pos_cmp = CMP_W'(pos_ff);
      cnt_cmp = CMP_W'(count_ff);

      stat.op          = op_ff;
      stat.full        = (count_ff == CNT_W'(CAPACITY));
      stat.empty       = (count_ff == '0);
      stat.pos_gt_cnt  = (pos_cmp > cnt_cmp);
      stat.pos_ge_cnt  = (pos_cmp >= cnt_cmp);
      stat.cur_at_pos  = (CMP_W'(cursor_ff) == pos_cmp);
      stat.cur_at_last = ((cursor_ff + CNT_W'(1)) == count_ff);

      case (cmd.cnt_op)
         CNT_INC: count_in = count_ff + CNT_W'(1);
         CNT_DEC: count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase

      case (cmd.cur_op)
         CUR_LOAD_COUNT: cursor_in = count_ff;
         CUR_LOAD_POS:   cursor_in = CNT_W'(pos_ff);
         CUR_INC:        cursor_in = cursor_ff + CNT_W'(1);
         CUR_DEC:        cursor_in = cursor_ff - CNT_W'(1);
         default:        cursor_in = cursor_ff;
      endcase

      case (cmd.wr_sel)
         WR_COUNT_VAL: begin
            wr_addr = ADDR_W'(count_ff);
            wr_data = val_ff;
         end
         WR_POS_VAL: begin
            wr_addr = ADDR_W'(pos_ff);
            wr_data = val_ff;
         end
         WR_CUR_SHIFT: begin
            wr_addr = ADDR_W'(cursor_ff);
            wr_data = mem_q_ff;
         end
         default: begin
            wr_addr = ADDR_W'(cursor_ff);
            wr_data = mem_q_ff;
         end
      endcase

      case (cmd.rd_sel)
         RD_POS:    rd_addr = ADDR_W'(pos_ff);
         RD_CUR_DN: rd_addr = ADDR_W'(cursor_ff - CNT_W'(1));
         RD_CUR_UP: rd_addr = ADDR_W'(cursor_ff + CNT_W'(1));
         default:   rd_addr = ADDR_W'(pos_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         entry_mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         mem_q_ff <= entry_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= op_type'(req_opcode);
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      cursor_ff <= cursor_in;
      if (cmd.rsp_load) begin
         rsp_data_ff   <= cmd.rsp_use_rd ? mem_q_ff : '0;
         rsp_count_ff  <= COUNT_OUT_W'(count_in);
         rsp_status_ff <= cmd.rsp_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_read_data   = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_status      = rsp_status_ff;

   `OLIE_ASSERT_NOW(a_inc_not_full, clock, reset, cmd.cnt_op == CNT_INC,
                    count_ff != CNT_W'(CAPACITY))
   `OLIE_ASSERT_NOW(a_dec_not_empty, clock, reset, cmd.cnt_op == CNT_DEC, count_ff != '0)
   `OLIE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(CAPACITY))

endmodule

`default_nettype wire

// ===== design/olie_ctrl.sv =====
// Controller state machine of the ordered list.
`default_nettype none

`include "ordered_list_insert_erase_assert.svh"

module olie_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  olie_pkg::stat_type stat,
   output olie_pkg::cmd_type  cmd
);
   import olie_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end

         S_EXEC: begin
            case (stat.op)
               OP_APPEND: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_RESP;
                  if (stat.full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.mem_wr     = 1'b1;
                     cmd.wr_sel     = WR_COUNT_VAL;
                     cmd.cnt_op     = CNT_INC;
                     cmd.rsp_status = ST_OK;
                  end
               end
               OP_POP: begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_OK;
                  state_in       = S_RESP;
                  if (!stat.empty) begin
                     cmd.cnt_op = CNT_DEC;
                  end
               end
               OP_INSERT: begin
                  if (stat.pos_gt_cnt) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                     state_in       = S_RESP;
                  end else if (stat.full) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_FULL;
                     state_in       = S_RESP;
                  end else begin
                     cmd.cur_op = CUR_LOAD_COUNT;
                     state_in   = S_SHIFT_RD;
                  end
               end
               OP_ERASE: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                     state_in       = S_RESP;
                  end else begin
                     cmd.cur_op = CUR_LOAD_POS;
                     state_in   = S_SHIFT_RD;
                  end
               end
               OP_READ: begin
                  if (stat.pos_ge_cnt) begin
                     cmd.rsp_load   = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                     state_in       = S_RESP;
                  end else begin
                     cmd.mem_rd = 1'b1;
                     cmd.rd_sel = RD_POS;
                     state_in   = S_READ;
                  end
               end
               OP_WRITE: begin
                  cmd.rsp_load = 1'b1;
                  state_in     = S_RESP;
                  if (stat.pos_ge_cnt) begin
                     cmd.rsp_status = ST_RANGE;
                  end else begin
                     cmd.mem_wr     = 1'b1;
                     cmd.wr_sel     = WR_POS_VAL;
                     cmd.rsp_status = ST_OK;
                  end
               end
               default: begin
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_OK;
                  state_in       = S_RESP;
               end
            endcase
         end

         S_SHIFT_RD: begin
            if (stat.op == OP_INSERT) begin
               if (stat.cur_at_pos) begin
                  cmd.mem_wr     = 1'b1;
                  cmd.wr_sel     = WR_POS_VAL;
                  cmd.cnt_op     = CNT_INC;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_OK;
                  state_in       = S_RESP;
               end else begin
                  cmd.mem_rd = 1'b1;
                  cmd.rd_sel = RD_CUR_DN;
                  state_in   = S_SHIFT_WR;
               end
            end else begin
               if (stat.cur_at_last) begin
                  cmd.cnt_op     = CNT_DEC;
                  cmd.rsp_load   = 1'b1;
                  cmd.rsp_status = ST_OK;
                  state_in       = S_RESP;
               end else begin
                  cmd.mem_rd = 1'b1;
                  cmd.rd_sel = RD_CUR_UP;
                  state_in   = S_SHIFT_WR;
               end
            end
         end

         S_SHIFT_WR: begin
            cmd.mem_wr = 1'b1;
            cmd.wr_sel = WR_CUR_SHIFT;
            cmd.cur_op = (stat.op == OP_INSERT) ? CUR_DEC : CUR_INC;
            state_in   = S_SHIFT_RD;
         end

         S_READ: begin
            cmd.rsp_load   = 1'b1;
            cmd.rsp_use_rd = 1'b1;
            cmd.rsp_status = ST_OK;
            state_in       = S_RESP;
         end

         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               req_ready = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `OLIE_ASSERT_NOW(a_rd_wr_exclusive, clock, reset, cmd.mem_wr, !cmd.mem_rd)
   `OLIE_ASSERT_NOW(a_read_follows_fetch, clock, reset, state_ff == S_READ,
                    $past(cmd.mem_rd) && $past(state_ff) == S_EXEC)
   `OLIE_ASSERT_NEXT(a_accept_starts_exec, clock, reset, cmd.load_req, state_ff == S_EXEC)

endmodule

`default_nettype wire

// ===== design/ordered_list_insert_erase.sv =====
// Ordered list top level: wires the controller and datapath to the channels.
// Append, remove last, write and rejected requests go from execute straight to response;
// read passes a memory read state first; insert or erase alternate shift read and shift
// write states per moved entry: one memory read and one write through one RAM port pair.
// One request at a time; the next request beat is taken on the response beat.
// Synchronous reset empties the list and idles the controller; entry memory is not cleared.
`default_nettype none

module ordered_list_insert_erase (
   input  logic        clock,
   input  logic        reset,
   olie_req_if.sink    req_chan,
   olie_rsp_if.source  rsp_chan
);
   import olie_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   olie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   olie_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_chan.opcode),
      .req_position    (req_chan.position),
      .req_value       (req_chan.value),
      .rsp_read_data   (rsp_chan.read_data),
      .rsp_entry_count (rsp_chan.entry_count),
      .rsp_status      (rsp_chan.status)
   );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the ordered list: queued requests, a shadow list predictor, response checking.
`timescale 1ns / 1ps

module tb;
   import olie_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int GEN_COPY = 0;
   localparam int CHK_COPY = 1;

   localparam int PH_FILL  = 0;
   localparam int PH_CHURN = 1;
   localparam int PH_DRAIN = 2;

   localparam int RX_OPEN    = 0;
   localparam int RX_COIN    = 1;
   localparam int RX_QUARTER = 2;
   localparam int RX_STALLS  = 3;

   localparam int DIRECTED_N     = 24;
   localparam int RANDOM_N       = 380;
   localparam int ITEM_TARGET    = DIRECTED_N + RANDOM_N;
   localparam int DRAIN_CYCLES   = 160;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_MAX     = 10;

   typedef struct {
      logic [OPCODE_W-1:0]      opcode;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      bit                       wait_idle;
   } list_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] read_data;
      logic [COUNT_OUT_W-1:0]   entry_count;
      status_type               status;
   } list_rsp_type;

   logic clock;
   logic reset;

   olie_req_if req_bus ();
   olie_rsp_if rsp_bus ();

   ordered_list_insert_erase u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   logic signed [DATA_W-1:0] list_mem [2][CAPACITY];
   int                       list_count [2];

   list_req_type pending_req[$];
   list_rsp_type expected_rsp[$];

   int n_sent;
   int n_recv;
   int fail_count;
   int mismatch_count;
   int quiet_cycles;
   int op_seen [8];
   int st_seen [4];

   int burst_left;
   int gap_left;
   int rx_mode;
   int rx_mode_left;
   int rx_stall_left;
   int rx_tick;

   always #1 clock = ~clock;

   function automatic list_rsp_type apply_request(input int cp, input list_req_type r);
      list_rsp_type o;
      int           cnt;
      int           p;
      int           i;
      cnt = list_count[cp];
      p = r.position;
      o.read_data = '0;
      o.status = ST_OK;
      case (r.opcode)
         OP_APPEND: begin
            if (cnt >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               list_mem[cp][cnt] = r.value;
               cnt++;
            end
         end
         OP_POP: begin
            if (cnt != 0) cnt--;
         end
         OP_INSERT: begin
            if (p > cnt) begin
               o.status = ST_RANGE;
            end else if (cnt >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               for (i = cnt; i > p; i--) list_mem[cp][i] = list_mem[cp][i-1];
               list_mem[cp][p] = r.value;
               cnt++;
            end
         end
         OP_ERASE: begin
            if (p >= cnt) begin
               o.status = ST_RANGE;
            end else begin
               for (i = p; i + 1 < cnt; i++) list_mem[cp][i] = list_mem[cp][i+1];
               cnt--;
            end
         end
         OP_READ: begin
            if (p >= cnt) o.status = ST_RANGE;
            else o.read_data = list_mem[cp][p];
         end
         OP_WRITE: begin
            if (p >= cnt) o.status = ST_RANGE;
            else list_mem[cp][p] = r.value;
         end
         default: ;
      endcase
      list_count[cp] = cnt;
      o.entry_count = COUNT_OUT_W'(cnt);
      return o;
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return -32'sd1;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(input logic [OPCODE_W-1:0] op, input int pos,
                                input logic signed [DATA_W-1:0] val, input bit hold);
      list_req_type r;
      r.opcode = op;
      r.position = POS_W'(pos);
      r.value = val;
      r.wait_idle = hold;
      pending_req = {pending_req, r};
      void'(apply_request(GEN_COPY, r));
   endtask

   task automatic random_request(input int phase, input bit hold);
      int                  pick;
      int                  lim;
      int                  pos;
      logic [OPCODE_W-1:0] op;
      pick = $urandom_range(0, 99);
      case (phase)
         PH_FILL:
            op = pick < 40 ? OP_APPEND : pick < 70 ? OP_INSERT : pick < 80 ? OP_READ :
                 pick < 90 ? OP_WRITE : pick < 93 ? OP_ERASE : pick < 95 ? OP_POP :
                 pick < 98 ? OP_SPARE_LO : OP_SPARE_HI;
         PH_CHURN:
            op = pick < 15 ? OP_APPEND : pick < 35 ? OP_INSERT : pick < 55 ? OP_ERASE :
                 pick < 65 ? OP_POP : pick < 80 ? OP_READ : pick < 95 ? OP_WRITE :
                 pick < 98 ? OP_SPARE_LO : OP_SPARE_HI;
         default:
            op = pick < 40 ? OP_ERASE : pick < 70 ? OP_POP : pick < 80 ? OP_READ :
                 pick < 90 ? OP_WRITE : pick < 95 ? OP_INSERT :
                 pick < 98 ? OP_SPARE_LO : OP_SPARE_HI;
      endcase
      lim = (op == OP_INSERT) ? list_count[GEN_COPY] : list_count[GEN_COPY] - 1;
      if (lim < 0 || $urandom_range(0, 99) < 15) pos = $urandom_range(0, 127);
      else pos = $urandom_range(0, lim);
      queue_request(op, pos, rand_word(), hold);
   endtask

   // driver
   always @(posedge clock) begin
      list_req_type cur;
      list_rsp_type want;
      bit           fire;
      fire = req_bus.valid && req_bus.ready;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (fire) begin
            cur = pending_req.pop_front();
            want = apply_request(CHK_COPY, cur);
            expected_rsp = {expected_rsp, want};
            n_sent++;
            op_seen[cur.opcode]++;
            st_seen[want.status]++;
         end
         if (req_bus.valid && !fire) begin
            // hold the beat until it is taken
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_req.size() != 0 &&
                      (!pending_req[0].wait_idle || n_sent == n_recv)) begin
            req_bus.valid    <= 1'b1;
            req_bus.opcode   <= pending_req[0].opcode;
            req_bus.position <= pending_req[0].position;
            req_bus.value    <= pending_req[0].value;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                       : $urandom_range(0, 2);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      list_rsp_type want;
      list_rsp_type got;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.read_data = rsp_bus.read_data;
            got.entry_count = rsp_bus.entry_count;
            got.status = status_type'(rsp_bus.status);
            n_recv <= n_recv + 1;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("unexpected beat: data %0d count %0d status %0d",
                           got.read_data, got.entry_count, got.status);
            end else begin
               want = expected_rsp.pop_front();
               if (got.read_data !== want.read_data || got.entry_count !== want.entry_count ||
                   got.status !== want.status) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= REPORT_MAX)
                     $display("mismatch on beat %0d: data %0d/%0d count %0d/%0d status %0d/%0d",
                              n_recv, want.read_data, got.read_data, want.entry_count,
                              got.entry_count, want.status, got.status);
               end
            end
         end
         rx_tick++;
         if (rx_mode_left <= 0) begin
            rx_mode = $urandom_range(RX_OPEN, RX_STALLS);
            rx_mode_left = $urandom_range(20, 120);
         end else begin
            rx_mode_left--;
         end
         case (rx_mode)
            RX_OPEN:    rsp_bus.ready <= 1'b1;
            RX_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_QUARTER: rsp_bus.ready <= (rx_tick % 4 == 0);
            default: begin
               if (rx_stall_left > 0) begin
                  rx_stall_left--;
                  rsp_bus.ready <= 1'b0;
               end else begin
                  rsp_bus.ready <= 1'b1;
                  if ($urandom_range(0, 9) == 0) rx_stall_left = $urandom_range(1, 12);
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[ordered_list_insert_erase] ERROR");
         $finish;
      end
   end

   initial begin
      bit hold;
      int guard;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.position = '0;
      req_bus.value = '0;
      rsp_bus.ready = 1'b0;
      n_sent = 0;
      n_recv = 0;
      fail_count = 0;
      mismatch_count = 0;
      quiet_cycles = 0;
      burst_left = 1;
      gap_left = 0;
      rx_mode = RX_OPEN;
      rx_mode_left = 0;
      rx_stall_left = 0;
      rx_tick = 0;
      for (int i = 0; i < 8; i++) op_seen[i] = 0;
      for (int i = 0; i < 4; i++) st_seen[i] = 0;
      list_count[GEN_COPY] = 0;
      list_count[CHK_COPY] = 0;
      for (int i = 0; i < CAPACITY; i++) begin
         list_mem[GEN_COPY][i] = '0;
         list_mem[CHK_COPY][i] = '0;
      end

      // empty list refusals and spare opcodes
      queue_request(OP_POP, 0, '0, 0);
      queue_request(OP_READ, 0, '0, 0);
      queue_request(OP_ERASE, 0, '0, 0);
      queue_request(OP_WRITE, 0, -32'sd1, 0);
      queue_request(OP_INSERT, 1, -32'sd1, 0);
      queue_request(OP_SPARE_LO, 127, -32'sd1, 0);
      queue_request(OP_SPARE_HI, 127, 32'sh5555_5555, 0);
      // build, read back, edit
      queue_request(OP_INSERT, 0, 32'sh8000_0000, 0);
      queue_request(OP_APPEND, 0, 32'sh7FFF_FFFF, 0);
      queue_request(OP_INSERT, 2, 32'shAAAA_AAAA, 0);
      queue_request(OP_INSERT, 0, 32'sh5555_5555, 0);
      for (int i = 0; i < 4; i++) queue_request(OP_READ, i, -32'sd1, 0);
      queue_request(OP_WRITE, 3, -32'sd1, 0);
      queue_request(OP_WRITE, 4, '0, 0);
      queue_request(OP_READ, 127, '0, 0);
      queue_request(OP_ERASE, 1, '0, 0);
      queue_request(OP_ERASE, 3, '0, 0);
      queue_request(OP_INSERT, 127, '0, 0);
      queue_request(OP_READ, 2, '0, 0);
      queue_request(OP_POP, 0, '0, 0);
      queue_request(OP_ERASE, 0, '0, 0);

      while (pending_req.size() < ITEM_TARGET) begin
         hold = 1;
         guard = 0;
         while (list_count[GEN_COPY] < CAPACITY && guard < 300 &&
                pending_req.size() < ITEM_TARGET) begin
            random_request(PH_FILL, hold);
            hold = 0;
            guard++;
         end
         // hammer the full list with adds at every kind of position
         repeat (10) begin
            if (pending_req.size() < ITEM_TARGET)
               queue_request($urandom_range(0, 1) ? OP_APPEND : OP_INSERT,
                             $urandom_range(0, 127), rand_word(), 0);
         end
         hold = 1;
         repeat (30) begin
            if (pending_req.size() < ITEM_TARGET) begin
               random_request(PH_CHURN, hold);
               hold = 0;
            end
         end
         guard = 0;
         while (list_count[GEN_COPY] > 0 && guard < 300 &&
                pending_req.size() < ITEM_TARGET) begin
            random_request(PH_DRAIN, 0);
            guard++;
         end
         repeat (3) begin
            if (pending_req.size() < ITEM_TARGET) random_request(PH_DRAIN, 0);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || n_recv != n_sent) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0) begin
         fail_count++;
         $display("%0d responses never arrived", expected_rsp.size());
      end

      $display("ran %0d requests: %0d append, %0d pop, %0d insert, %0d erase, %0d read, %0d write",
               n_sent, op_seen[OP_APPEND], op_seen[OP_POP], op_seen[OP_INSERT],
               op_seen[OP_ERASE], op_seen[OP_READ], op_seen[OP_WRITE]);
      $display("spare opcodes %0d, refused full %0d, refused range %0d, responses checked %0d",
               op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI], st_seen[ST_FULL],
               st_seen[ST_RANGE], n_recv);
      if (fail_count == 0) begin
         $display("[ordered_list_insert_erase] OK");
      end else begin
         $display("[ordered_list_insert_erase] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/olie_pkg.sv
design/olie_req_if.sv
design/olie_rsp_if.sv
design/olie_dp.sv
design/olie_ctrl.sv
design/ordered_list_insert_erase.sv
dv/tb.sv
